/* design/rice_bitstream_decoder_defines.svh */
// ----------------------------------------------------------------------------
// Rice bitstream decoder assertion macros
// Shared property macros for the decoder checks, clocked on i_clk and
// disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef RICE_BITSTREAM_DECODER_DEFINES_SVH
`define RICE_BITSTREAM_DECODER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RBD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("rice decoder check failed");

// The consequent must hold in the cycle after the antecedent.
`define RBD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("rice decoder check failed");

`endif

/* design/rbd_pkg.sv */
// ----------------------------------------------------------------------------
// Rice bitstream decoder package
// Shared constants, codes and structures of the Rice bitstream decoder.
// ----------------------------------------------------------------------------
package rbd_pkg;

    localparam int MAX_FIELD_BITS = 32;
    localparam int BYTE_BITS      = 8;
    localparam int ACC_W          = 32;
    localparam int VALUE_W        = 33;
    localparam int CNT_W          = 6;
    localparam int LEFT_W         = 4;
    localparam int TDATA_OUT_W    = 40;

    localparam logic [1:0] MODE_UNSIGNED = 2'd0;
    localparam logic [1:0] MODE_SIGNED   = 2'd1;
    localparam logic [1:0] MODE_RICE     = 2'd2;

    localparam logic [1:0] REG_MODE  = 2'd0;
    localparam logic [1:0] REG_WIDTH = 2'd1;
    localparam logic [1:0] REG_PARAM = 2'd2;

    localparam logic [1:0] RST_MODE  = MODE_RICE;
    localparam logic [5:0] RST_WIDTH = 6'd8;
    localparam logic [4:0] RST_PARAM = 5'd4;

    localparam logic [VALUE_W-1:0] SAT_POS = 33'h0_7FFF_FFFF;
    localparam logic [VALUE_W-1:0] SAT_NEG = 33'h1_8000_0000;

    typedef struct packed {
        logic [1:0]       mode;
        logic [CNT_W-1:0] width;
        logic [4:0]       param;
    } t_cfg;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               overflow;
    } t_result;

    typedef struct packed {
        logic              valid;
        logic              bit_val;
        logic              last;
        logic [LEFT_W-1:0] left;
    } t_bit_src;

endpackage

/* design/rbd_bit_shifter.sv */
// ----------------------------------------------------------------------------
// Rice bitstream decoder byte shifter
// Takes one byte per transaction and hands it out one bit per step,
// most significant bit first.
// ----------------------------------------------------------------------------
module rbd_bit_shifter (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_tvalid,
    output logic                        o_tready,
    input  logic [rbd_pkg::BYTE_BITS-1:0] i_tdata,
    input  logic                        i_step,
    output rbd_pkg::t_bit_src           o_src
);

    logic [rbd_pkg::BYTE_BITS-1:0] r_byte;
    logic [rbd_pkg::LEFT_W-1:0]    r_left;
    logic                          accept;

    assign o_tready = (r_left == '0) ||
                      (r_left == rbd_pkg::LEFT_W'(1) && i_step);
    assign accept   = i_tvalid && o_tready;

    assign o_src.valid   = (r_left != '0);
    assign o_src.bit_val = r_byte[rbd_pkg::BYTE_BITS-1];
    assign o_src.last    = (r_left == rbd_pkg::LEFT_W'(1));
    assign o_src.left    = r_left;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else if (accept) begin
            r_left <= rbd_pkg::LEFT_W'(rbd_pkg::BYTE_BITS);
        end else if (i_step) begin
            r_left <= r_left - rbd_pkg::LEFT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_byte <= i_tdata;
        end else if (i_step) begin
            r_byte <= {r_byte[rbd_pkg::BYTE_BITS-2:0], 1'b0};
        end
    end

endmodule

/* design/rbd_code_core.sv */
// ----------------------------------------------------------------------------
// Rice bitstream decoder code core
// Consumes one stream bit per step and builds fixed fields or Rice codes
// in a shifting accumulator, flagging a result when a code completes.
// ----------------------------------------------------------------------------
module rbd_code_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_clear,
    input  logic             i_step,
    input  logic             i_bit,
    input  rbd_pkg::t_cfg    i_cfg,
    output logic             o_emit,
    output rbd_pkg::t_result o_res
);

    logic [rbd_pkg::ACC_W-1:0]   r_acc;
    logic [rbd_pkg::ACC_W-1:0]   n_acc;
    logic [rbd_pkg::CNT_W-1:0]   r_cnt;
    logic [rbd_pkg::CNT_W-1:0]   n_cnt;
    logic                        r_rem;
    logic                        n_rem;
    logic                        r_qovf;
    logic                        n_qovf;
    logic [rbd_pkg::CNT_W-1:0]   cnt_inc;
    logic [rbd_pkg::ACC_W-1:0]   shifted;
    logic [rbd_pkg::ACC_W-1:0]   u_val;
    logic                        u_ovf;
    logic                        fixed_mode;
    logic                        emit;

    assign fixed_mode = (i_cfg.mode == rbd_pkg::MODE_UNSIGNED) ||
                        (i_cfg.mode == rbd_pkg::MODE_SIGNED);
    assign cnt_inc    = r_cnt + rbd_pkg::CNT_W'(1);
    assign o_emit     = emit;

    always_comb begin
        n_acc   = r_acc;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        n_qovf  = r_qovf;
        emit    = 1'b0;
        u_val   = r_acc;
        u_ovf   = r_qovf;
        shifted = {r_acc[rbd_pkg::ACC_W-2:0], i_bit};
        o_res   = '0;

        if (fixed_mode) begin
            // A signed field starts with its sign copied into every upper bit.
            if (r_cnt == '0 && i_cfg.mode == rbd_pkg::MODE_SIGNED) begin
                shifted = {rbd_pkg::ACC_W{i_bit}};
            end
            n_acc = shifted;
            n_cnt = cnt_inc;
            emit  = (cnt_inc >= i_cfg.width);
            if (i_cfg.mode == rbd_pkg::MODE_SIGNED) begin
                o_res.value = {shifted[rbd_pkg::ACC_W-1], shifted};
            end else begin
                o_res.value = {1'b0, shifted};
            end
        end else begin
            if (!r_rem) begin
                if (!i_bit) begin
                    if (&r_acc) begin
                        n_qovf = 1'b1;
                    end else begin
                        n_acc = r_acc + rbd_pkg::ACC_W'(1);
                    end
                end else if (i_cfg.param == '0) begin
                    emit = 1'b1;
                end else begin
                    n_rem = 1'b1;
                    n_cnt = '0;
                end
            end else begin
                u_val = shifted;
                u_ovf = r_qovf | r_acc[rbd_pkg::ACC_W-1];
                n_acc = shifted;
                n_qovf = u_ovf;
                n_cnt = cnt_inc;
                emit  = (cnt_inc >= {1'b0, i_cfg.param});
            end
            if (u_ovf) begin
                o_res.value    = u_val[0] ? rbd_pkg::SAT_NEG : rbd_pkg::SAT_POS;
                o_res.overflow = 1'b1;
            end else if (u_val[0]) begin
                o_res.value = ~{2'b00, u_val[rbd_pkg::ACC_W-1:1]};
            end else begin
                o_res.value = {2'b00, u_val[rbd_pkg::ACC_W-1:1]};
            end
        end

        if (emit) begin
            n_acc  = '0;
            n_cnt  = '0;
            n_rem  = 1'b0;
            n_qovf = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_acc  <= '0;
            r_cnt  <= '0;
            r_rem  <= 1'b0;
            r_qovf <= 1'b0;
        end else if (i_step) begin
            r_acc  <= n_acc;
            r_cnt  <= n_cnt;
            r_rem  <= n_rem;
            r_qovf <= n_qovf;
        end
    end

endmodule

/* design/rbd_result_buf.sv */
// ----------------------------------------------------------------------------
// Rice bitstream decoder result buffer
// Holds the newest result until it is known whether it is the last one of
// its byte, and drives the output register of the result stream.
// ----------------------------------------------------------------------------
module rbd_result_buf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic             i_last_bit,
    input  logic             i_emit,
    input  rbd_pkg::t_result i_res,
    input  logic             i_tready,
    output logic             o_tvalid,
    output rbd_pkg::t_result o_res,
    output logic             o_tlast,
    output logic             o_stall
);

    logic             r_out_valid;
    rbd_pkg::t_result r_out_res;
    logic             r_out_last;
    logic             r_pend_valid;
    logic             r_pend_closed;
    rbd_pkg::t_result r_pend_res;
    logic             out_free;
    logic             take_new;
    logic             push_open;
    logic             flush;

    assign out_free  = !r_out_valid || i_tready;
    assign o_stall   = r_pend_valid && (r_pend_closed || !out_free);
    assign take_new  = i_step && i_emit;
    assign push_open = take_new && r_pend_valid;
    assign flush     = r_pend_valid && r_pend_closed && out_free;

    assign o_tvalid = r_out_valid;
    assign o_res    = r_out_res;
    assign o_tlast  = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (push_open || flush) begin
            r_out_valid <= 1'b1;
        end else if (i_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_open || flush) begin
            r_out_res  <= r_pend_res;
            r_out_last <= r_pend_closed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid  <= 1'b0;
            r_pend_closed <= 1'b0;
        end else if (take_new) begin
            r_pend_valid  <= 1'b1;
            r_pend_closed <= i_last_bit;
        end else if (i_step && i_last_bit && r_pend_valid) begin
            r_pend_closed <= 1'b1;
        end else if (flush) begin
            r_pend_valid  <= 1'b0;
            r_pend_closed <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_new) begin
            r_pend_res <= i_res;
        end
    end

endmodule

/* design/rice_bitstream_decoder.sv */
// ----------------------------------------------------------------------------
// Rice bitstream decoder
// Decodes fixed unsigned, fixed signed or Rice codes from a byte stream,
// most significant bit first, with codes spanning byte boundaries.
//
// Channel   Direction  Contents
// s_axis    in         tdata[7:0] data_byte
// m_axis    out        tdata[32:0] value, tuser overflow, tlast last_of_run
// apb       in/out     decode_mode 0x0, field_width 0x4, rice_param 0x8
//
// Bits leave the byte shift register one bit per cycle while the bit steps
// are not stalled; a byte that produced results holds the steps until its
// final result is sent. A new byte is taken in the cycle its predecessor's
// last bit is consumed. Backpressure on m_axis holds the bit steps.
// Reset is synchronous and clears all control state and restores the
// register defaults; any register write discards a partial code.
// ----------------------------------------------------------------------------
`include "rice_bitstream_decoder_defines.svh"

module rice_bitstream_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    // Result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [32:0] value, [39:33] zero
    output logic        m_axis_tuser,   // [0] overflow
    output logic        m_axis_tlast
);

    logic [1:0]                r_mode;
    logic [rbd_pkg::CNT_W-1:0] r_width;
    logic [4:0]                r_param;
    logic                      cfg_wr;
    logic                      cfg_hit;
    logic [1:0]                cfg_idx;
    rbd_pkg::t_cfg             cfg;
    rbd_pkg::t_bit_src         src;
    logic                      step;
    logic                      stall;
    logic                      emit;
    rbd_pkg::t_result          core_res;
    rbd_pkg::t_result          out_res;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_hit = cfg_wr && (cfg_idx == rbd_pkg::REG_MODE ||
                                cfg_idx == rbd_pkg::REG_WIDTH ||
                                cfg_idx == rbd_pkg::REG_PARAM);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= rbd_pkg::RST_MODE;
            r_width <= rbd_pkg::RST_WIDTH;
            r_param <= rbd_pkg::RST_PARAM;
        end else if (cfg_wr) begin
            case (cfg_idx)
                rbd_pkg::REG_MODE:  r_mode  <= pwdata[1:0];
                rbd_pkg::REG_WIDTH: r_width <= pwdata[rbd_pkg::CNT_W-1:0];
                rbd_pkg::REG_PARAM: r_param <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            rbd_pkg::REG_MODE:  prdata = {30'd0, r_mode};
            rbd_pkg::REG_WIDTH: prdata = {26'd0, r_width};
            rbd_pkg::REG_PARAM: prdata = {27'd0, r_param};
            default:            prdata = '0;
        endcase
    end

    always_comb begin
        cfg.mode  = r_mode;
        cfg.param = r_param;
        if (r_width == '0) begin
            cfg.width = rbd_pkg::CNT_W'(1);
        end else if (r_width > rbd_pkg::CNT_W'(rbd_pkg::MAX_FIELD_BITS)) begin
            cfg.width = rbd_pkg::CNT_W'(rbd_pkg::MAX_FIELD_BITS);
        end else begin
            cfg.width = r_width;
        end
    end

    assign step = src.valid && !stall;

    rbd_bit_shifter u_shifter (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tvalid (s_axis_tvalid),
        .o_tready (s_axis_tready),
        .i_tdata  (s_axis_tdata),
        .i_step   (step),
        .o_src    (src)
    );

    rbd_code_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (cfg_hit),
        .i_step  (step),
        .i_bit   (src.bit_val),
        .i_cfg   (cfg),
        .o_emit  (emit),
        .o_res   (core_res)
    );

    rbd_result_buf u_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (step),
        .i_last_bit (src.last),
        .i_emit     (emit),
        .i_res      (core_res),
        .i_tready   (m_axis_tready),
        .o_tvalid   (m_axis_tvalid),
        .o_res      (out_res),
        .o_tlast    (m_axis_tlast),
        .o_stall    (stall)
    );

    assign m_axis_tdata = {{(rbd_pkg::TDATA_OUT_W - rbd_pkg::VALUE_W){1'b0}}, out_res.value};
    assign m_axis_tuser = out_res.overflow;

    `RBD_ASSERT_NEXT(a_load_full_byte, s_axis_tvalid && s_axis_tready && i_rst_n,
        src.left == rbd_pkg::LEFT_W'(rbd_pkg::BYTE_BITS))
    `RBD_ASSERT_SAME(a_overflow_saturates, m_axis_tvalid && m_axis_tuser,
        out_res.value == rbd_pkg::SAT_POS || out_res.value == rbd_pkg::SAT_NEG)
    `RBD_ASSERT_SAME(a_fixed_no_overflow, m_axis_tvalid &&
        (r_mode == rbd_pkg::MODE_UNSIGNED || r_mode == rbd_pkg::MODE_SIGNED), !m_axis_tuser)
    `RBD_ASSERT_SAME(a_rice_fits_32, m_axis_tvalid && r_mode[1],
        out_res.value[32] == out_res.value[31])

endmodule
